>>> hdl/pctmr_pkg.sv
package pctmr_pkg;

   localparam int unsigned PRESCALE_W  = 4;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned BYTE_W      = 8;

   localparam int unsigned CTRL_ENABLE_BIT    = 0;
   localparam int unsigned CTRL_ONE_PULSE_BIT = 3;
   localparam int unsigned IRQ_UPDATE_EN_BIT  = 0;
   localparam int unsigned STATUS_UPDATE_BIT  = 0;

   localparam logic [COUNT_W-1:0] RELOAD_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_CTRL      = 3'd0,
      REG_IRQ_EN    = 3'd1,
      REG_STATUS    = 3'd2,
      REG_CNT_HIGH  = 3'd3,
      REG_CNT_LOW   = 3'd4,
      REG_PRESCALE  = 3'd5,
      REG_RELOAD_HI = 3'd6,
      REG_RELOAD_LO = 3'd7
   } reg_index_type;

   typedef struct packed {
      req_kind_type  req_type;
      reg_index_type reg_index;
      logic [BYTE_W-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic              update_irq;
      logic [BYTE_W-1:0] read_data;
   } result_type;

endpackage

>>> hdl/pctmr_engine.sv
module pctmr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  pctmr_pkg::item_type   item,
   output pctmr_pkg::result_type result
);
   import pctmr_pkg::*;

   logic [BYTE_W-1:0]     control_ff,   control_in;
   logic [BYTE_W-1:0]     irq_en_ff,    irq_en_in;
   logic [BYTE_W-1:0]     status_ff,    status_in;
   logic [COUNT_W-1:0]    counter_ff,   counter_in;
   logic [COUNT_W-1:0]    reload_ff,    reload_in;
   logic [PRESCALE_W-1:0] prescale_ff,  prescale_in;
   logic [COUNT_W-1:0]    pre_count_ff, pre_count_in;

   logic [COUNT_W-1:0] ratio;
   logic [COUNT_W-1:0] pre_inc;
   logic [COUNT_W-1:0] cnt_inc;
   logic               step;
   logic               hit;

   assign ratio   = COUNT_W'(1) << prescale_ff;
   assign pre_inc = pre_count_ff + COUNT_W'(1);
   assign step    = (pre_inc >= ratio);
   assign cnt_inc = counter_ff + COUNT_W'(1);
   assign hit     = (cnt_inc == reload_ff);

   always_comb begin
      control_in   = control_ff;
      irq_en_in    = irq_en_ff;
      status_in    = status_ff;
      counter_in   = counter_ff;
      reload_in    = reload_ff;
      prescale_in  = prescale_ff;
      pre_count_in = pre_count_ff;
      result       = '0;
      case (item.req_type)
         REQ_TICK: begin
            if (control_ff[CTRL_ENABLE_BIT]) begin
               pre_count_in = pre_inc;
               if (step) begin
                  pre_count_in = pre_inc - ratio;
                  counter_in   = cnt_inc;
                  if (hit) begin
                     counter_in = '0;
                     status_in[STATUS_UPDATE_BIT] = 1'b1;
                     if (control_ff[CTRL_ONE_PULSE_BIT]) begin
                        control_in[CTRL_ENABLE_BIT] = 1'b0;
                     end
                     result.update_irq = irq_en_ff[IRQ_UPDATE_EN_BIT];
                  end
               end
            end
         end
         REQ_WRITE: begin
            case (item.reg_index)
               REG_CTRL:      control_in = item.write_data;
               REG_IRQ_EN:    irq_en_in  = item.write_data;
               REG_STATUS:    status_in  = item.write_data;
               REG_CNT_HIGH:  counter_in = {item.write_data, counter_ff[BYTE_W-1:0]};
               REG_CNT_LOW:   counter_in = {counter_ff[COUNT_W-1:BYTE_W], item.write_data};
               REG_PRESCALE:  prescale_in = item.write_data[PRESCALE_W-1:0];
               REG_RELOAD_HI: reload_in  = {item.write_data, reload_ff[BYTE_W-1:0]};
               REG_RELOAD_LO: reload_in  = {reload_ff[COUNT_W-1:BYTE_W], item.write_data};
               default:       control_in = control_ff;
            endcase
         end
         REQ_READ: begin
            case (item.reg_index)
               REG_CTRL:      result.read_data = control_ff;
               REG_IRQ_EN:    result.read_data = irq_en_ff;
               REG_STATUS:    result.read_data = status_ff;
               REG_CNT_HIGH:  result.read_data = counter_ff[COUNT_W-1:BYTE_W];
               REG_CNT_LOW:   result.read_data = counter_ff[BYTE_W-1:0];
               REG_PRESCALE:  result.read_data = BYTE_W'(prescale_ff);
               REG_RELOAD_HI: result.read_data = reload_ff[COUNT_W-1:BYTE_W];
               REG_RELOAD_LO: result.read_data = reload_ff[BYTE_W-1:0];
               default:       result.read_data = '0;
            endcase
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         irq_en_ff    <= '0;
         status_ff    <= '0;
         counter_ff   <= '0;
         reload_ff    <= RELOAD_RESET;
         prescale_ff  <= '0;
         pre_count_ff <= '0;
      end else if (fire) begin
         control_ff   <= control_in;
         irq_en_ff    <= irq_en_in;
         status_ff    <= status_in;
         counter_ff   <= counter_in;
         reload_ff    <= reload_in;
         prescale_ff  <= prescale_in;
         pre_count_ff <= pre_count_in;
      end
   end

endmodule

>>> hdl/prescaled_up_counter_timer_core.sv
// Prescaled 16-bit up-counting timer with auto-reload and a byte-wide
// register file, driven by a stream of transactions. Each request is a tick,
// a register write or a register read (kind in req_tuser) and produces
// exactly one response: the read byte for a read (zero otherwise) and an
// update interrupt pulse when a tick wrapped the counter at the reload value
// with the update interrupt enabled. Ticks only count while ctrl bit 0 is
// set; the prescaler divides ticks by 2^prescale; on a match the counter
// clears, status bit 0 sets and, in one-pulse mode (ctrl bit 3), the enable
// bit drops. The prescale register keeps only its low 4 bits. Throughput is
// one transaction per clock while responses are taken. The request register
// feeds the register update and response logic, which is done in a single
// logic step into the response register that drives response valid.
// A stalled response holds the pipeline; req_tready falls only when both
// stages are full and rsp_tready is low.
module prescaled_up_counter_timer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] reg_index, [10:3] write_data, [15:11] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] read_data, [8] update_irq, [15:9] zero
);
   import pctmr_pkg::*;

   item_type   item_ff, item_in;
   logic       item_valid_ff;
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_fire;

   // the request stage moves on whenever the response slot is free or draining
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign item_in.req_type   = req_kind_type'(req_tuser);
   assign item_in.reg_index  = reg_index_type'(req_tdata[2:0]);
   assign item_in.write_data = req_tdata[10:3];

   pctmr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .result (rsp_in)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_fire) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.update_irq, rsp_ff.read_data};

   // interrupt pulses come only from ticks
   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.req_type != REQ_TICK |=> !rsp_ff.update_irq)
      else $error("update_irq raised by a non-tick transaction");

   // read data is zero for anything but a read
   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.req_type != REQ_READ |=> rsp_ff.read_data == '0)
      else $error("nonzero read_data on a non-read transaction");

   // a blocked request stays in the request register
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("pending request lost while stalled");

   // every request moved on produces a visible response
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("response missing after request advanced");

   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !item_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
